/* hw/rtl/clcd_pkg.sv */
// Package for the character LCD controller: opcodes, command codes,
// controller states, datapath command struct and fixed store sizes.
// Used by clcd_ctrl, clcd_dp and character_lcd_controller.
`default_nettype none

package clcd_pkg;

    localparam int GLYPH_DEPTH = 64;
    localparam int GLYPH_AW    = 6;
    localparam int GLYPH_W     = 5;
    localparam int DADDR_W     = 7;

    localparam logic [7:0] SPACE_CHAR     = 8'h20;

    localparam logic [7:0] CMD_FUNC_MASK  = 8'he0;
    localparam logic [7:0] CMD_FUNC       = 8'h20;
    localparam logic [7:0] CMD_DISP_MASK  = 8'hf8;
    localparam logic [7:0] CMD_DISP       = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MASK = 8'hfc;
    localparam logic [7:0] CMD_ENTRY      = 8'h04;
    localparam logic [7:0] CMD_GADDR_MASK = 8'hc0;
    localparam logic [7:0] CMD_GADDR      = 8'h40;
    localparam logic [7:0] CMD_DADDR_MASK = 8'h80;
    localparam logic [7:0] CMD_DADDR      = 8'h80;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_DRD  = 2'd2,
        OP_GRD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_ctl_state;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_SPACE,
        RS_DRAM,
        RS_GRAM
    } t_rd_sel;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hw/rtl/clcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/clcd_ctrl.sv */
// Controller state machine: sequences capture, execute and result load,
// and owns the valid/stall handshakes. Depends on clcd_pkg.
`default_nettype none

module clcd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output clcd_pkg::t_dp_cmd     o_cmd
);

    clcd_pkg::t_ctl_state r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic                 take_out;

    assign take_out = r_out_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = clcd_pkg::S_EXEC;
                end
            end
            clcd_pkg::S_EXEC: begin
                n_state = clcd_pkg::S_LOAD;
            end
            clcd_pkg::S_LOAD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = clcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clcd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_stall       = 1'b1;
        unique case (r_state)
            clcd_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            clcd_pkg::S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            clcd_pkg::S_LOAD: begin
                o_cmd.load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (take_out) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clcd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == clcd_pkg::S_EXEC)
        else $error("request capture not followed by execute");

    a_exec_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == clcd_pkg::S_EXEC |=> r_state == clcd_pkg::S_LOAD)
        else $error("execute not followed by result load");

    a_load_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == clcd_pkg::S_LOAD && r_out_valid && i_stall)
        |=> r_state == clcd_pkg::S_LOAD && r_out_valid)
        else $error("pending result overwritten");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* hw/rtl/clcd_dp.sv */
// Datapath: request registers, address counters, mode flags, display and
// glyph stores with valid bits, result register. Depends on clcd_pkg, clcd_ram.
`default_nettype none

module clcd_dp #(
    parameter int DISPLAY_DEPTH = 80,
    parameter int LINE_LENGTH   = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire clcd_pkg::t_dp_cmd i_cmd,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [7:0]        i_value,
    input  wire logic [6:0]        i_read_index,
    output logic      [7:0]        o_read_data,
    output logic      [6:0]        o_display_address,
    output logic      [5:0]        o_glyph_address,
    output logic                   o_display_mode,
    output logic                   o_display_on,
    output logic                   o_cursor_on,
    output logic                   o_blink_on,
    output logic                   o_two_lines,
    output logic                   o_count_up,
    output logic                   o_shift_on,
    output logic                   o_wide_bus,
    output logic                   o_large_font
);

    localparam int DA_W = $clog2(DISPLAY_DEPTH);
    localparam int AW   = clcd_pkg::DADDR_W;
    localparam int GW   = clcd_pkg::GLYPH_AW;
    localparam logic [AW-1:0]   DEPTH_A = AW'(DISPLAY_DEPTH);
    localparam logic [AW-1:0]   LINE_A  = AW'(LINE_LENGTH);
    localparam logic [AW-2:0]   LINE_C  = (AW-1)'(LINE_LENGTH);

    clcd_pkg::t_opcode r_op;
    logic [7:0]        r_value;
    logic [6:0]        r_ri;

    logic [AW-1:0]     r_daddr;
    logic [GW-1:0]     r_gaddr;
    logic              r_dmode, r_disp_on, r_cur_on, r_blink_on, r_two_lines;
    logic              r_count_up, r_shift_on, r_wide_bus, r_large_font;

    logic [DISPLAY_DEPTH-1:0]         r_dvalid;
    logic [clcd_pkg::GLYPH_DEPTH-1:0] r_gvalid;
    clcd_pkg::t_rd_sel                r_rsel, n_rsel;

    logic [AW-2:0]     col;
    logic [AW-1:0]     didx;
    logic              d_ok, d_we, g_we, d_re, g_re, ri_in_range;
    logic [AW-1:0]     n_daddr_step;
    logic [GW-1:0]     n_gaddr_step;
    logic [7:0]        d_q;
    logic [clcd_pkg::GLYPH_W-1:0] g_q;
    logic [7:0]        rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= clcd_pkg::t_opcode'(i_opcode);
            r_value <= i_value;
            r_ri    <= i_read_index;
        end
    end

    always_comb begin
        col  = r_daddr[AW-2:0];
        didx = r_daddr;
        if (r_two_lines) begin
            didx = {1'b0, col} + (r_daddr[AW-1] ? LINE_A : '0);
        end
        d_ok = (!r_two_lines || col < LINE_C) && didx < DEPTH_A;
        d_we = i_cmd.execute && r_op == clcd_pkg::OP_DATA && r_dmode && d_ok;
        g_we = i_cmd.execute && r_op == clcd_pkg::OP_DATA && !r_dmode;
        d_re = i_cmd.execute && r_op == clcd_pkg::OP_DRD;
        g_re = i_cmd.execute && r_op == clcd_pkg::OP_GRD;
        ri_in_range  = r_ri < DEPTH_A;
        n_daddr_step = r_count_up ? r_daddr + 1'b1 : r_daddr - 1'b1;
        n_gaddr_step = r_count_up ? r_gaddr + 1'b1 : r_gaddr - 1'b1;
    end

    always_comb begin
        n_rsel = clcd_pkg::RS_ZERO;
        unique case (r_op)
            clcd_pkg::OP_DRD: begin
                if (ri_in_range) begin
                    n_rsel = r_dvalid[r_ri[DA_W-1:0]] ? clcd_pkg::RS_DRAM
                                                      : clcd_pkg::RS_SPACE;
                end
            end
            clcd_pkg::OP_GRD: begin
                if (r_gvalid[r_ri[GW-1:0]]) begin
                    n_rsel = clcd_pkg::RS_GRAM;
                end
            end
            clcd_pkg::OP_CMD, clcd_pkg::OP_DATA: begin
                n_rsel = clcd_pkg::RS_ZERO;
            end
            default: begin
                n_rsel = clcd_pkg::RS_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_rsel <= n_rsel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_daddr      <= '0;
            r_gaddr      <= '0;
            r_dmode      <= 1'b0;
            r_disp_on    <= 1'b0;
            r_cur_on     <= 1'b0;
            r_blink_on   <= 1'b0;
            r_two_lines  <= 1'b0;
            r_count_up   <= 1'b0;
            r_shift_on   <= 1'b0;
            r_wide_bus   <= 1'b0;
            r_large_font <= 1'b0;
            r_dvalid     <= '0;
            r_gvalid     <= '0;
        end else if (i_cmd.execute) begin
            if (r_op == clcd_pkg::OP_CMD) begin
                priority if ((r_value & clcd_pkg::CMD_FUNC_MASK) == clcd_pkg::CMD_FUNC) begin
                    r_wide_bus   <= r_value[4];
                    r_two_lines  <= r_value[3];
                    r_large_font <= r_value[2];
                end else if ((r_value & clcd_pkg::CMD_DISP_MASK) == clcd_pkg::CMD_DISP) begin
                    r_disp_on  <= r_value[2];
                    r_cur_on   <= r_value[1];
                    r_blink_on <= r_value[0];
                end else if (r_value == clcd_pkg::CMD_CLEAR) begin
                    r_daddr    <= '0;
                    r_count_up <= 1'b1;
                    r_dvalid   <= '0;
                end else if (r_value == clcd_pkg::CMD_HOME) begin
                    r_daddr <= '0;
                end else if ((r_value & clcd_pkg::CMD_ENTRY_MASK) == clcd_pkg::CMD_ENTRY) begin
                    r_count_up <= r_value[1];
                    r_shift_on <= r_value[0];
                end else if ((r_value & clcd_pkg::CMD_GADDR_MASK) == clcd_pkg::CMD_GADDR) begin
                    r_gaddr <= r_value[GW-1:0];
                    r_dmode <= 1'b0;
                end else if ((r_value & clcd_pkg::CMD_DADDR_MASK) == clcd_pkg::CMD_DADDR) begin
                    r_daddr <= r_value[AW-1:0];
                    r_dmode <= 1'b1;
                end else begin
                end
            end else if (r_op == clcd_pkg::OP_DATA) begin
                if (r_dmode) begin
                    r_daddr <= n_daddr_step;
                    if (d_ok) begin
                        r_dvalid[didx[DA_W-1:0]] <= 1'b1;
                    end
                end else begin
                    r_gaddr           <= n_gaddr_step;
                    r_gvalid[r_gaddr] <= 1'b1;
                end
            end
        end
    end

    clcd_ram #(
        .WIDTH (8),
        .DEPTH (DISPLAY_DEPTH)
    ) u_disp_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (didx[DA_W-1:0]),
        .i_wdata (r_value),
        .i_re    (d_re),
        .i_raddr (r_ri[DA_W-1:0]),
        .o_rdata (d_q)
    );

    clcd_ram #(
        .WIDTH (clcd_pkg::GLYPH_W),
        .DEPTH (clcd_pkg::GLYPH_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (r_gaddr),
        .i_wdata (r_value[clcd_pkg::GLYPH_W-1:0]),
        .i_re    (g_re),
        .i_raddr (r_ri[GW-1:0]),
        .o_rdata (g_q)
    );

    always_comb begin
        unique case (r_rsel)
            clcd_pkg::RS_DRAM:  rd_data = d_q;
            clcd_pkg::RS_SPACE: rd_data = clcd_pkg::SPACE_CHAR;
            clcd_pkg::RS_GRAM:  rd_data = {{(8 - clcd_pkg::GLYPH_W){1'b0}}, g_q};
            default:            rd_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_read_data       <= rd_data;
            o_display_address <= r_daddr;
            o_glyph_address   <= r_gaddr;
            o_display_mode    <= r_dmode;
            o_display_on      <= r_disp_on;
            o_cursor_on       <= r_cur_on;
            o_blink_on        <= r_blink_on;
            o_two_lines       <= r_two_lines;
            o_count_up        <= r_count_up;
            o_shift_on        <= r_shift_on;
            o_wide_bus        <= r_wide_bus;
            o_large_font      <= r_large_font;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/character_lcd_controller.sv */
// Character LCD controller, write side with store read-back.
// A request goes through execute, then load, set by the registered store read and the
// capture/execute/load sequencer; a new request is taken only after the previous is loaded.
// A waiting result does not block acceptance of the next request, but holds its load.
// Synchronous active-low reset clears counters, flags and store valid bits at once;
// unwritten entries read as spaces (display) or zero (glyph); clear empties the display.
`default_nettype none

module character_lcd_controller #(
    parameter int DISPLAY_DEPTH = 80,
    parameter int LINE_LENGTH   = 40
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_value,
    input  wire logic [6:0] i_read_index,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [7:0] o_read_data,
    output logic      [6:0] o_display_address,
    output logic      [5:0] o_glyph_address,
    output logic            o_display_mode,
    output logic            o_display_on,
    output logic            o_cursor_on,
    output logic            o_blink_on,
    output logic            o_two_lines,
    output logic            o_count_up,
    output logic            o_shift_on,
    output logic            o_wide_bus,
    output logic            o_large_font
);

    clcd_pkg::t_dp_cmd dp_cmd;

    clcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    clcd_dp #(
        .DISPLAY_DEPTH (DISPLAY_DEPTH),
        .LINE_LENGTH   (LINE_LENGTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_opcode          (i_opcode),
        .i_value           (i_value),
        .i_read_index      (i_read_index),
        .o_read_data       (o_read_data),
        .o_display_address (o_display_address),
        .o_glyph_address   (o_glyph_address),
        .o_display_mode    (o_display_mode),
        .o_display_on      (o_display_on),
        .o_cursor_on       (o_cursor_on),
        .o_blink_on        (o_blink_on),
        .o_two_lines       (o_two_lines),
        .o_count_up        (o_count_up),
        .o_shift_on        (o_shift_on),
        .o_wide_bus        (o_wide_bus),
        .o_large_font      (o_large_font)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for character_lcd_controller: drives bus requests and predicts each result.
// The prediction keeps its own copy of both stores, the counters and the flags.
// Depends on clcd_pkg and the character_lcd_controller RTL.
`timescale 1ns / 100ps

module tb;

    localparam int DISP_DEPTH = 80;
    localparam int LINE_LEN   = 40;

    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] display_address;
        logic [5:0] glyph_address;
        logic       display_mode;
        logic       display_on;
        logic       cursor_on;
        logic       blink_on;
        logic       two_lines;
        logic       count_up;
        logic       shift_on;
        logic       wide_bus;
        logic       large_font;
    } t_lcd_status;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_opcode     = '0;
    logic [7:0] i_value      = '0;
    logic [6:0] i_read_index = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic [6:0] o_display_address;
    logic [5:0] o_glyph_address;
    logic       o_display_mode;
    logic       o_display_on;
    logic       o_cursor_on;
    logic       o_blink_on;
    logic       o_two_lines;
    logic       o_count_up;
    logic       o_shift_on;
    logic       o_wide_bus;
    logic       o_large_font;

    logic [7:0]  char_shadow [DISP_DEPTH];
    logic [4:0]  glyph_shadow [clcd_pkg::GLYPH_DEPTH];
    t_lcd_status lcd_state;
    t_lcd_status pending_results [$];

    int unsigned fail_count = 0;
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_left  = 0;

    character_lcd_controller #(
        .DISPLAY_DEPTH (DISP_DEPTH),
        .LINE_LENGTH   (LINE_LEN)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_value           (i_value),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_display_address (o_display_address),
        .o_glyph_address   (o_glyph_address),
        .o_display_mode    (o_display_mode),
        .o_display_on      (o_display_on),
        .o_cursor_on       (o_cursor_on),
        .o_blink_on        (o_blink_on),
        .o_two_lines       (o_two_lines),
        .o_count_up        (o_count_up),
        .o_shift_on        (o_shift_on),
        .o_wide_bus        (o_wide_bus),
        .o_large_font      (o_large_font)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic lcd_reset_state();
        foreach (char_shadow[k]) char_shadow[k] = clcd_pkg::SPACE_CHAR;
        foreach (glyph_shadow[k]) glyph_shadow[k] = '0;
        lcd_state = '0;
    endtask

    task automatic predict_lcd_result(input clcd_pkg::t_opcode op, input logic [7:0] v,
                                      input logic [6:0] ri);
        t_lcd_status res;
        logic [6:0]  addr;
        int unsigned slot;
        bit          keep;
        logic [7:0]  rd;
        rd = '0;
        case (op)
            clcd_pkg::OP_CMD: begin
                if ((v & clcd_pkg::CMD_FUNC_MASK) == clcd_pkg::CMD_FUNC) begin
                    lcd_state.wide_bus   = v[4];
                    lcd_state.two_lines  = v[3];
                    lcd_state.large_font = v[2];
                end else if ((v & clcd_pkg::CMD_DISP_MASK) == clcd_pkg::CMD_DISP) begin
                    lcd_state.display_on = v[2];
                    lcd_state.cursor_on  = v[1];
                    lcd_state.blink_on   = v[0];
                end else if (v == clcd_pkg::CMD_CLEAR) begin
                    foreach (char_shadow[k]) char_shadow[k] = clcd_pkg::SPACE_CHAR;
                    lcd_state.display_address = '0;
                    lcd_state.count_up        = 1'b1;
                end else if (v == clcd_pkg::CMD_HOME) begin
                    lcd_state.display_address = '0;
                end else if ((v & clcd_pkg::CMD_ENTRY_MASK) == clcd_pkg::CMD_ENTRY) begin
                    lcd_state.count_up = v[1];
                    lcd_state.shift_on = v[0];
                end else if ((v & clcd_pkg::CMD_GADDR_MASK) == clcd_pkg::CMD_GADDR) begin
                    lcd_state.glyph_address = v[5:0];
                    lcd_state.display_mode  = 1'b0;
                end else if ((v & clcd_pkg::CMD_DADDR_MASK) == clcd_pkg::CMD_DADDR) begin
                    lcd_state.display_address = v[6:0];
                    lcd_state.display_mode    = 1'b1;
                end
            end
            clcd_pkg::OP_DATA: begin
                if (!lcd_state.display_mode) begin
                    glyph_shadow[lcd_state.glyph_address] = v[4:0];
                    if (lcd_state.count_up) lcd_state.glyph_address += 6'd1;
                    else lcd_state.glyph_address -= 6'd1;
                end else begin
                    addr = lcd_state.display_address;
                    if (lcd_state.two_lines) begin
                        keep = (addr[5:0] < LINE_LEN);
                        slot = addr[5:0] + (addr[6] ? LINE_LEN : 0);
                    end else begin
                        keep = 1'b1;
                        slot = addr;
                    end
                    if (keep && slot < DISP_DEPTH) char_shadow[slot] = v;
                    if (lcd_state.count_up) lcd_state.display_address = addr + 7'd1;
                    else lcd_state.display_address = addr - 7'd1;
                end
            end
            clcd_pkg::OP_DRD: begin
                if (ri < DISP_DEPTH) rd = char_shadow[ri];
            end
            clcd_pkg::OP_GRD: begin
                rd = {3'b000, glyph_shadow[ri[5:0]]};
            end
        endcase
        res = lcd_state;
        res.read_data = rd;
        pending_results.push_back(res);
    endtask

    task automatic send_req(input clcd_pkg::t_opcode op, input logic [7:0] v,
                            input logic [6:0] ri);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_value      <= v;
        i_read_index <= ri;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_lcd_result(op, v, ri);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_lcd_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("display_address", want.display_address, o_display_address);
                check_field("glyph_address", want.glyph_address, o_glyph_address);
                check_field("display_mode", want.display_mode, o_display_mode);
                check_field("display_on", want.display_on, o_display_on);
                check_field("cursor_on", want.cursor_on, o_cursor_on);
                check_field("blink_on", want.blink_on, o_blink_on);
                check_field("two_lines", want.two_lines, o_two_lines);
                check_field("count_up", want.count_up, o_count_up);
                check_field("shift_on", want.shift_on, o_shift_on);
                check_field("wide_bus", want.wide_bus, o_wide_bus);
                check_field("large_font", want.large_font, o_large_font);
            end
        end
    end

    function automatic logic [7:0] rand_command();
        case ($urandom_range(0, 7))
            0: return clcd_pkg::CMD_FUNC | 8'($urandom_range(0, 31));
            1: return clcd_pkg::CMD_DISP | 8'($urandom_range(0, 7));
            2: return clcd_pkg::CMD_CLEAR;
            3: return clcd_pkg::CMD_HOME;
            4: return clcd_pkg::CMD_ENTRY | 8'($urandom_range(0, 3));
            5: return clcd_pkg::CMD_GADDR | 8'($urandom_range(0, 63));
            6: return clcd_pkg::CMD_DADDR | 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [6:0] rand_index(input clcd_pkg::t_opcode op);
        if (op == clcd_pkg::OP_DRD && $urandom_range(0, 3) != 0)
            return 7'($urandom_range(0, 79));
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic test_reset_reads();
        send_req(clcd_pkg::OP_DRD, 8'h00, 7'd0);
        send_req(clcd_pkg::OP_DRD, 8'hff, 7'd79);
        send_req(clcd_pkg::OP_DRD, 8'h00, 7'd80);
        send_req(clcd_pkg::OP_DRD, 8'hff, 7'd127);
        send_req(clcd_pkg::OP_GRD, 8'h00, 7'd0);
        send_req(clcd_pkg::OP_GRD, 8'hff, 7'd127);
    endtask

    task automatic test_commands();
        send_req(clcd_pkg::OP_CMD, 8'h00, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_FUNC | 8'h1c, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_DISP | 8'h07, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_ENTRY | 8'h03, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_FUNC, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_DISP, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_ENTRY, 7'd0);
        send_req(clcd_pkg::OP_CMD, 8'h03, 7'd127);
    endtask

    task automatic test_glyph_writes();
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_GADDR, 7'd0);
        send_req(clcd_pkg::OP_DATA, 8'hff, 7'd0);
        send_req(clcd_pkg::OP_GRD, 8'h00, 7'd64);
    endtask

    task automatic test_display_writes();
        send_req(clcd_pkg::OP_CMD, 8'hff, 7'd0);
        send_req(clcd_pkg::OP_DATA, 8'ha5, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_FUNC | 8'h08, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_DADDR | 8'h67, 7'd0);
        send_req(clcd_pkg::OP_DATA, 8'h5a, 7'd0);
        send_req(clcd_pkg::OP_DRD, 8'h00, 7'd79);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_DADDR | 8'h28, 7'd0);
        send_req(clcd_pkg::OP_DATA, 8'h11, 7'd0);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_CLEAR, 7'd0);
        send_req(clcd_pkg::OP_DRD, 8'h00, 7'd79);
        send_req(clcd_pkg::OP_CMD, clcd_pkg::CMD_HOME, 7'd0);
    endtask

    task automatic test_random(input int unsigned n);
        int unsigned       sent;
        int unsigned       burst;
        clcd_pkg::t_opcode op;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 25) begin
                if ($urandom_range(0, 1) != 0)
                    send_req(clcd_pkg::OP_CMD,
                             clcd_pkg::CMD_DADDR | 8'($urandom_range(0, 127)), 7'($urandom));
                else
                    send_req(clcd_pkg::OP_CMD,
                             clcd_pkg::CMD_GADDR | 8'($urandom_range(0, 63)), 7'($urandom));
                burst = $urandom_range(1, 6);
                repeat (burst) send_req(clcd_pkg::OP_DATA, 8'($urandom), 7'($urandom));
                sent += burst + 1;
            end else begin
                op = clcd_pkg::t_opcode'($urandom_range(0, 3));
                send_req(op, (op == clcd_pkg::OP_CMD) ? rand_command() : 8'($urandom),
                         rand_index(op));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        clcd_pkg::t_opcode op;
        hold_left = 80;
        repeat (24) begin
            op = clcd_pkg::t_opcode'($urandom_range(0, 3));
            send_req(op, (op == clcd_pkg::OP_CMD) ? rand_command() : 8'($urandom),
                     rand_index(op));
        end
    endtask

    initial begin
        lcd_reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_reads();
        test_commands();
        test_glyph_writes();
        test_display_writes();

        idle_pct = 0;  stall_pct = 0;
        test_random(110);
        test_backpressure();
        idle_pct = 69; stall_pct = 0;
        test_random(130);
        idle_pct = 0;  stall_pct = 69;
        test_random(130);
        idle_pct = 28; stall_pct = 28;
        test_random(130);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
